/* rtl/core/dpmn_pkg.sv */
// ----------------------------------------------------------------------------
// dpmn_pkg: shared definitions for the DisplayPort M/N ratio calculator
// Field widths, link rate codes, N limits and the rate code lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package dpmn_pkg;

   // Field widths of one input item and one result item.
   localparam int BPC_W    = 5;
   localparam int KHZ_W    = 20;
   localparam int MN_W     = 24;
   localparam int LINK_N_W = 21;

   // Configuration register widths and reset values.
   localparam int CODE_W = 8;
   localparam int LANE_W = 3;
   localparam logic [CODE_W-1:0] LINK_RATE_RESET  = 8'd10;
   localparam logic [LANE_W-1:0] LANE_COUNT_RESET = 3'd4;

   // Register index, taken from the APB word address.
   localparam logic REG_LINK_RATE  = 1'b0;
   localparam logic REG_LANE_COUNT = 1'b1;

   // Link rate codes as reported by the sink.
   localparam logic [CODE_W-1:0] CODE_162 = 8'h06;
   localparam logic [CODE_W-1:0] CODE_270 = 8'h0A;
   localparam logic [CODE_W-1:0] CODE_540 = 8'h14;

   // Symbol rates in Hz; all fit in 30 bits.
   localparam int RATE_W = 30;
   localparam logic [RATE_W-1:0] RATE_162 = 30'd162000000;
   localparam logic [RATE_W-1:0] RATE_270 = 30'd270000000;
   localparam logic [RATE_W-1:0] RATE_540 = 30'd540000000;

   // Pixel clock in Hz is kHz times 1000; fits in 30 bits.
   localparam int HZ_W = 30;
   localparam logic [HZ_W-1:0] KHZ_TO_HZ = 30'd1000;

   // Upper limits of the two N values, as powers of two.
   localparam int DATA_N_LOG2 = 23;
   localparam int LINK_N_LOG2 = 20;
   localparam logic [MN_W-1:0] DATA_N_LIMIT = 24'h800000;
   localparam logic [MN_W-1:0] LINK_N_LIMIT = 24'h100000;

   typedef struct packed {
      logic              known;
      logic [RATE_W-1:0] rate;
   } rate_info_type;

   function automatic rate_info_type rate_of_code(input logic [CODE_W-1:0] code);
      rate_info_type info;
      info.known = 1'b1;
      case (code)
         CODE_162: info.rate = RATE_162;
         CODE_270: info.rate = RATE_270;
         CODE_540: info.rate = RATE_540;
         default: begin
            info.known = 1'b0;
            info.rate  = '0;
         end
      endcase
      return info;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/dp_link_m_n_ratio_calc_core.sv */
// ----------------------------------------------------------------------------
// dp_link_m_n_ratio_calc_core: DisplayPort data and link M/N calculator
// Computes the reduced data M/N and link M/N pairs for one display mode.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Contents
//   req_*     in         tvalid/tready         bits per component, pixel clock
//   rsp_*     out        tvalid/tready         data M/N, link M/N, rate error
//   csr_*     in/out     APB psel/penable      link rate code, lane count
//
// An accepted item passes through these steps in order: a multiply of kHz to
// Hz, a multiply by three times bpc, then for each pair a load step, a shared
// restoring divider that produces one quotient bit per cycle for all 30
// quotient bits, halving until M fits 24 bits and a closing step, and finally
// the load of the result register. With a lane count of zero the data pass is
// skipped. An unknown link rate code skips the arithmetic and goes straight to
// the result register.
// req_tready is high only while the sequencer is idle. A finished result
// sits in the output register; a new item may be accepted meanwhile, and the
// sequencer holds its next result back until the previous one is taken.
// Reset is synchronous and active high; it clears the sequencer, the output
// valid flag and sets both configuration registers to their reset values.
//
// Arithmetic: both N values always exceed their limits for a valid rate, so
// each N becomes its limit (2^23 for data, 2^20 for link) and
// M' = floor(M * 2^k / N_old). The quotient is always below 2^30, which lets
// the divider start with the upper part of the dividend as its remainder
// and shift in only the lower 30 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module dp_link_m_n_ratio_calc_core (
   input  wire logic         clock,
   input  wire logic         reset,

   // Input items.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [4:0] bits_per_component, [24:5] pixel_clock_khz, [31:25] zero
   input  wire logic [31:0]  req_tdata,

   // Result items.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [23:0] data_m, [47:24] data_n, [71:48] link_m, [92:72] link_n, [95:93] zero
   output logic [95:0]       rsp_tdata,
   // [0] rate_error
   output logic              rsp_tuser,

   // Configuration port.
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import dpmn_pkg::*;

   localparam int DIV_STEPS = 30;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int BPC3_W    = BPC_W + 2;
   localparam int M_W       = HZ_W + BPC3_W;       // data M before division
   localparam int DIVR_W    = 35;                  // 8 * rate * lanes < 2^35
   localparam int QUO_W     = DIV_STEPS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_HZ,
      ST_MUL_M,
      ST_LOAD,
      ST_DIV,
      ST_HALVE,
      ST_DONE
   } state_type;

   // ------------------------------------------------------------------------
   // Configuration registers. pready is always high, so a write lands at the
   // access cycle.
   // ------------------------------------------------------------------------
   logic [CODE_W-1:0] link_rate_code_ff;
   logic [LANE_W-1:0] lane_count_ff;
   logic              csr_write;
   logic              csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         link_rate_code_ff <= LINK_RATE_RESET;
         lane_count_ff     <= LANE_COUNT_RESET;
      end else if (csr_write) begin
         if (csr_index == REG_LINK_RATE) begin
            link_rate_code_ff <= csr_pwdata[CODE_W-1:0];
         end else begin
            lane_count_ff <= csr_pwdata[LANE_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_index == REG_LANE_COUNT) begin
         csr_prdata = {{(32-LANE_W){1'b0}}, lane_count_ff};
      end else begin
         csr_prdata = {{(32-CODE_W){1'b0}}, link_rate_code_ff};
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer and datapath registers.
   // ------------------------------------------------------------------------
   state_type           state_ff, state_in;
   logic                link_pass_ff, link_pass_in;    // second pass: link pair
   logic                err_ff, err_in;
   logic [BPC3_W-1:0]   bpc3_ff, bpc3_in;
   logic [KHZ_W-1:0]    khz_ff, khz_in;
   logic [HZ_W-1:0]     clk_hz_ff, clk_hz_in;
   logic [M_W-1:0]      m_ff, m_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [DIVR_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;              // low dividend bits, then quotient
   logic [DIVR_W-1:0]   divisor_ff, divisor_in;
   logic [MN_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [MN_W-1:0]     data_m_ff, data_m_in;
   logic [MN_W-1:0]     data_n_ff, data_n_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [92:0]         rsp_data_ff, rsp_data_in;
   logic                rsp_user_ff, rsp_user_in;

   logic [BPC_W-1:0]    req_bpc;
   logic [KHZ_W-1:0]    req_khz;
   rate_info_type       rate_info;
   logic [31:0]         rate_lanes;
   logic [DIVR_W:0]     rem_shift;
   logic [DIVR_W:0]     rem_sub;
   logic                quo_bit;
   logic                out_load;

   assign req_bpc    = req_tdata[4:0];
   assign req_khz    = req_tdata[24:5];
   assign rate_info  = rate_of_code(link_rate_code_ff);
   assign rate_lanes = 32'(rate_ff) * 32'(lane_count_ff);

   // One restoring division step: shift in the next dividend bit and
   // subtract the divisor when it fits.
   assign rem_shift = {rem_ff, quo_ff[QUO_W-1]};
   assign rem_sub   = rem_shift - {1'b0, divisor_ff};
   assign quo_bit   = (rem_shift >= {1'b0, divisor_ff});

   assign out_load  = (state_ff == ST_DONE) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      link_pass_in  = link_pass_ff;
      err_in        = err_ff;
      bpc3_in       = bpc3_ff;
      khz_in        = khz_ff;
      clk_hz_in     = clk_hz_ff;
      m_in          = m_ff;
      rate_in       = rate_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      divisor_in    = divisor_ff;
      n_in          = n_ff;
      cnt_in        = cnt_ff;
      data_m_in     = data_m_ff;
      data_n_in     = data_n_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               bpc3_in      = {2'b00, req_bpc} + {1'b0, req_bpc, 1'b0};
               khz_in       = req_khz;
               rate_in      = rate_info.rate;
               err_in       = ~rate_info.known;
               link_pass_in = 1'b0;
               state_in     = rate_info.known ? ST_MUL_HZ : ST_DONE;
            end
         end
         ST_MUL_HZ: begin
            clk_hz_in = HZ_W'(khz_ff) * KHZ_TO_HZ;
            state_in  = ST_MUL_M;
         end
         ST_MUL_M: begin
            m_in     = M_W'(clk_hz_ff) * M_W'(bpc3_ff);
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cnt_in = CNT_W'(DIV_STEPS - 1);
            if (link_pass_ff) begin
               // clock_hz * 2^20 / link rate
               rem_in     = DIVR_W'(clk_hz_ff[HZ_W-1:QUO_W-LINK_N_LOG2]);
               quo_in     = {clk_hz_ff[QUO_W-LINK_N_LOG2-1:0], {LINK_N_LOG2{1'b0}}};
               divisor_in = DIVR_W'(rate_ff);
               n_in       = LINK_N_LIMIT;
               state_in   = ST_DIV;
            end else if (lane_count_ff == '0) begin
               // No lanes means a zero data N, and the data pair is zero.
               data_m_in    = '0;
               data_n_in    = '0;
               link_pass_in = 1'b1;
            end else begin
               // 3 * bpc * clock_hz * 2^23 / (8 * link rate * lanes)
               rem_in     = DIVR_W'(m_ff[M_W-1:QUO_W-DATA_N_LOG2]);
               quo_in     = {m_ff[QUO_W-DATA_N_LOG2-1:0], {DATA_N_LOG2{1'b0}}};
               divisor_in = {rate_lanes, 3'b000};
               n_in       = DATA_N_LIMIT;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = quo_bit ? rem_sub[DIVR_W-1:0] : rem_shift[DIVR_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], quo_bit};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_HALVE;
            end
         end
         ST_HALVE: begin
            if (|quo_ff[QUO_W-1:MN_W]) begin
               quo_in = quo_ff >> 1;
               n_in   = n_ff >> 1;
            end else if (!link_pass_ff) begin
               data_m_in    = quo_ff[MN_W-1:0];
               data_n_in    = n_ff;
               link_pass_in = 1'b1;
               state_in     = ST_LOAD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               rsp_tvalid_in = 1'b1;
               rsp_user_in   = err_ff;
               if (err_ff) begin
                  rsp_data_in = '0;
               end else begin
                  rsp_data_in = {n_ff[LINK_N_W-1:0], quo_ff[MN_W-1:0], data_n_ff, data_m_ff};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         link_pass_ff  <= 1'b0;
         err_ff        <= 1'b0;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         link_pass_ff  <= link_pass_in;
         err_ff        <= err_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         bpc3_ff       <= bpc3_in;
         khz_ff        <= khz_in;
         clk_hz_ff     <= clk_hz_in;
         m_ff          <= m_in;
         rate_ff       <= rate_in;
         rem_ff        <= rem_in;
         quo_ff        <= quo_in;
         divisor_ff    <= divisor_in;
         n_ff          <= n_in;
         data_m_ff     <= data_m_in;
         data_n_ff     <= data_n_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_user_ff   <= rsp_user_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};
   assign rsp_tuser  = rsp_user_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("block still ready in the cycle after accepting an item");

   a_error_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("rate error result carries nonzero M/N fields");

   a_n_power_of_two: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |->
         ($onehot0(rsp_tdata[47:24]) && $onehot0(rsp_tdata[92:72])))
      else $error("reduced N is not a power of two");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the completion state");

endmodule

`default_nettype wire
